FILE: design/brdr_pkg.sv
// Package for the byte ring with delimited reads: shared types, codes and defaults.
// Used by brdr_match and the top level in the design folder; depends on nothing else.
`timescale 1ns / 1ps
package brdr_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam logic [7:0] END_FIRST_RESET  = 8'd13;
   localparam logic [7:0] END_SECOND_RESET = 8'd10;
   localparam logic [6:0] PKT_MAX          = 7'd127;

   typedef enum logic [1:0] {
      ST_STORED  = 2'd0,
      ST_DROPPED = 2'd1,
      ST_MSG     = 2'd2,
      ST_NONE    = 2'd3
   } status_type;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CSR_END_FIRST  = 2'd0,
      CSR_END_SECOND = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_EMIT_RD,
      S_EMIT_OUT,
      S_ZERO_A,
      S_ZERO_B
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
   } match_ctl_type;

endpackage

FILE: design/brdr_mem.sv
// Byte storage of the ring: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module brdr_mem #(
   parameter int DEPTH = 64,
   parameter int PTR_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/brdr_match.sv
// Terminator compare unit: holds the previously scanned byte and flags the two-byte end mark.
// Depends on brdr_pkg for the control struct.
`timescale 1ns / 1ps
module brdr_match
   import brdr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  match_ctl_type ctl,
   input  logic [7:0]    cur_byte,
   input  logic [7:0]    end_first,
   input  logic [7:0]    end_second,
   output logic          hit
);

   logic [7:0] prev_ff;
   logic       prev_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         prev_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         prev_valid_ff <= 1'b1;
      end
      if (ctl.load) begin
         prev_ff <= cur_byte;
      end
   end

   assign hit = prev_valid_ff && (prev_ff == end_first) && (cur_byte == end_second);

endmodule

FILE: design/byte_ring_with_delimited_reads.sv
// Byte ring with delimited reads, top level: sequencer, pointers, counts and result register.
// A write word gives its result in the cycle after acceptance; while rsp_ready is high,
// writes can follow every cycle. A read word scans each stored byte through the single memory
// read port (S_SCAN_RD, S_SCAN_CHK), then emits each message byte (S_EMIT_RD, S_EMIT_OUT),
// with any wait on rsp_ready; no word is taken meanwhile. Reset clears pointers, counts
// and state; storage is not cleared, since reads only reach bytes that have been written.
`timescale 1ns / 1ps
module byte_ring_with_delimited_reads
   import brdr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   input  logic [5:0] req_packet_len,
   input  logic       req_first_of_packet,
   input  logic       req_last_of_packet,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + (PTR_W + 1)'(k);
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         sum = sum - (PTR_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [6:0]       pkts_ff, pkts_in;
   logic             accepted_ff, accepted_in;
   logic [7:0]       end_first_ff, end_second_ff;
   logic [PTR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] msg_len_ff, msg_len_in;
   logic [PTR_W-1:0] emit_addr_ff, emit_addr_in;
   logic [CNT_W-1:0] emit_left_ff, emit_left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             mem_we;
   logic [PTR_W-1:0] mem_waddr;
   logic [7:0]       mem_wdata;
   logic             mem_re;
   logic [PTR_W-1:0] mem_raddr;
   logic [7:0]       mem_rdata;
   match_ctl_type    match_ctl;
   logic             match_hit;
   logic             req_fire;
   logic             acc_now;
   logic             do_store;

   brdr_mem #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   brdr_match u_match (
      .clock      (clock),
      .reset      (reset),
      .ctl        (match_ctl),
      .cur_byte   (mem_rdata),
      .end_first  (end_first_ff),
      .end_second (end_second_ff),
      .hit        (match_hit)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign acc_now   = req_first_of_packet ? (7'(free_ff) > {1'b0, req_packet_len})
                                          : accepted_ff;
   assign do_store  = acc_now && (free_ff > CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         end_first_ff  <= END_FIRST_RESET;
         end_second_ff <= END_SECOND_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_END_FIRST:  end_first_ff  <= csr_wdata;
            CSR_END_SECOND: end_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         free_ff      <= CNT_W'(DEPTH);
         pkts_ff      <= '0;
         accepted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         free_ff      <= free_in;
         pkts_ff      <= pkts_in;
         accepted_ff  <= accepted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_addr_ff  <= scan_addr_in;
      scan_cnt_ff   <= scan_cnt_in;
      msg_len_ff    <= msg_len_in;
      emit_addr_ff  <= emit_addr_in;
      emit_left_ff  <= emit_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      free_in       = free_ff;
      pkts_in       = pkts_ff;
      accepted_in   = accepted_ff;
      scan_addr_in  = scan_addr_ff;
      scan_cnt_in   = scan_cnt_ff;
      msg_len_in    = msg_len_ff;
      emit_addr_in  = emit_addr_ff;
      emit_left_in  = emit_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = wp_ff;
      mem_wdata     = req_data_byte;
      mem_re        = 1'b0;
      mem_raddr     = scan_addr_ff;
      match_ctl     = '{clear: 1'b0, load: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (mode_type'(req_mode) == MODE_WRITE) begin
                  if (do_store) begin
                     mem_we  = 1'b1;
                     wp_in   = ring_add(wp_ff, 2'd1);
                     free_in = free_ff - CNT_W'(1);
                  end
                  if (req_last_of_packet) begin
                     if (acc_now && (pkts_ff < PKT_MAX)) begin
                        pkts_in = pkts_ff + 7'd1;
                     end
                     accepted_in = 1'b0;
                  end else begin
                     accepted_in = acc_now;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = do_store ? ST_STORED : ST_DROPPED;
                  rsp_last_in   = 1'b1;
               end else if (pkts_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NONE;
                  rsp_last_in   = 1'b1;
               end else begin
                  scan_addr_in    = rp_ff;
                  scan_cnt_in     = '0;
                  match_ctl.clear = 1'b1;
                  state_in        = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (scan_addr_ff == wp_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               mem_re   = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (match_hit) begin
               msg_len_in   = scan_cnt_ff - CNT_W'(1);
               emit_left_in = scan_cnt_ff - CNT_W'(1);
               emit_addr_in = rp_ff;
               if (scan_cnt_ff == CNT_W'(1)) begin
                  state_in = S_ZERO_A;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end else begin
               match_ctl.load = 1'b1;
               scan_cnt_in    = scan_cnt_ff + CNT_W'(1);
               scan_addr_in   = ring_add(scan_addr_ff, 2'd1);
               state_in       = S_SCAN_RD;
            end
         end
         S_EMIT_RD: begin
            mem_re        = 1'b1;
            mem_raddr     = emit_addr_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_MSG;
            rsp_last_in   = (emit_left_ff == CNT_W'(1));
            state_in      = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (rsp_ready) begin
               emit_addr_in = ring_add(emit_addr_ff, 2'd1);
               emit_left_in = emit_left_ff - CNT_W'(1);
               if (rsp_last_ff) begin
                  rp_in    = ring_add(emit_addr_ff, 2'd3);
                  free_in  = free_ff + msg_len_ff + CNT_W'(2);
                  pkts_in  = pkts_ff - 7'd1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_ZERO_A: begin
            mem_we    = 1'b1;
            mem_waddr = rp_ff;
            mem_wdata = '0;
            state_in  = S_ZERO_B;
         end
         S_ZERO_B: begin
            mem_we        = 1'b1;
            mem_waddr     = ring_add(rp_ff, 2'd1);
            mem_wdata     = '0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_NONE;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_out_byte = (rsp_status_ff == ST_MSG) ? mem_rdata : 8'd0;

   logic [PTR_W:0] ring_used;
   assign ring_used = (wp_ff >= rp_ff) ? {1'b0, wp_ff} - {1'b0, rp_ff}
                                       : {1'b0, wp_ff} + (PTR_W + 1)'(DEPTH) - {1'b0, rp_ff};

   a_space_matches_pointers: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(ring_used) + (CNT_W + 1)'(free_ff) == (CNT_W + 1)'(DEPTH))
      else $error("free space disagrees with pointer distance");

   a_one_slot_free: assert property (@(posedge clock) disable iff (reset)
      free_ff >= CNT_W'(1))
      else $error("ring filled its last slot");

   a_no_result_while_scanning: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD || state_ff == S_SCAN_CHK) |-> !rsp_valid_ff)
      else $error("result pending during scan");

   a_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT_OUT |-> rsp_valid_ff && rsp_status_ff == ST_MSG)
      else $error("message byte not presented");

   a_packets_drop_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_OUT && rsp_ready && rsp_last_ff) |=> pkts_ff == $past(pkts_ff) - 7'd1)
      else $error("packet count not reduced after message");

endmodule

FILE: dv/byte_ring_with_delimited_reads_tb.sv
// Self-checking testbench for byte_ring_with_delimited_reads: packet writes and terminator reads
// are checked word by word against a ring model kept here, over several terminator settings.
// Depends on brdr_pkg and the byte_ring_with_delimited_reads top level in the design folder.
`timescale 1ns / 1ps
module byte_ring_with_delimited_reads_tb;
   import brdr_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int QUIET_CYCLES = 300;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      mode_type mode;
      logic [7:0] data;
      logic [5:0] len;
      logic first;
      logic last;
   } ring_op_type;

   typedef struct {
      logic [7:0] data;
      status_type st;
      logic last;
   } ring_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = MODE_WRITE;
   logic [7:0] req_data_byte = 8'h00;
   logic [5:0] req_packet_len = 6'd0;
   logic req_first_of_packet = 1'b0;
   logic req_last_of_packet = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_END_FIRST;
   logic [7:0] csr_wdata = 8'h00;

   ring_op_type ring_ops[$];
   ring_word_type ring_results_due[$];
   ring_op_type on_wire;

   logic [7:0] ring_mem[RING_DEPTH];
   int wr_ptr = 0;
   int rd_ptr = 0;
   int free_cnt = RING_DEPTH;
   int pkt_cnt = 0;
   bit pkt_ok = 1'b0;
   logic [7:0] term_a = END_FIRST_RESET;
   logic [7:0] term_b = END_SECOND_RESET;

   int send_idle_pct = 28;
   int recv_idle_pct = 80;
   int stim_phase = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int ops_planned = 0;
   int words_sent = 0;
   int words_checked = 0;
   int msg_bytes = 0;
   int dropped_bytes = 0;
   int fail_count = 0;

   byte_ring_with_delimited_reads DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_data_byte(req_data_byte),
      .req_packet_len(req_packet_len),
      .req_first_of_packet(req_first_of_packet),
      .req_last_of_packet(req_last_of_packet),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
   end

   function automatic void ring_step(ring_op_type op);
      ring_word_type w;
      int pos;
      int nxt;
      int mlen;
      int k;
      bit found;
      w.data = 8'h00;
      w.st = ST_DROPPED;
      w.last = 1'b1;
      if (op.mode == MODE_WRITE) begin
         if (op.first) pkt_ok = (free_cnt > op.len);
         if (pkt_ok && free_cnt > 1) begin
            ring_mem[wr_ptr] = op.data;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            free_cnt--;
            w.st = ST_STORED;
         end
         if (op.last) begin
            if (pkt_ok && pkt_cnt < PKT_MAX) pkt_cnt++;
            pkt_ok = 1'b0;
         end
         ring_results_due.push_back(w);
      end else begin
         w.st = ST_NONE;
         pos = rd_ptr;
         mlen = 0;
         found = 1'b0;
         if (pkt_cnt != 0) begin
            for (k = 0; k < RING_DEPTH && pos != wr_ptr && !found; k++) begin
               nxt = (pos + 1) % RING_DEPTH;
               if (nxt != wr_ptr && ring_mem[pos] == term_a && ring_mem[nxt] == term_b) begin
                  found = 1'b1;
               end else begin
                  pos = nxt;
                  mlen++;
               end
            end
         end
         if (!found) begin
            ring_results_due.push_back(w);
         end else if (mlen == 0) begin
            ring_mem[pos] = 8'h00;
            ring_mem[(pos + 1) % RING_DEPTH] = 8'h00;
            ring_results_due.push_back(w);
         end else begin
            for (k = 0; k < mlen; k++) begin
               w.data = ring_mem[(rd_ptr + k) % RING_DEPTH];
               w.st = ST_MSG;
               w.last = (k + 1 == mlen);
               ring_results_due.push_back(w);
            end
            for (k = 0; k < mlen + 2; k++) ring_mem[(rd_ptr + k) % RING_DEPTH] = 8'h00;
            rd_ptr = (rd_ptr + mlen + 2) % RING_DEPTH;
            free_cnt += mlen + 2;
            pkt_cnt--;
         end
      end
   endfunction

   task automatic push_op(mode_type mode, logic [7:0] data, logic [5:0] len, logic first,
                          logic last);
      ring_op_type op;
      op.mode = mode;
      op.data = data;
      op.len = len;
      op.first = first;
      op.last = last;
      ring_ops.push_back(op);
      ops_planned++;
   endtask

   task automatic push_read();
      push_op(MODE_READ, 8'($urandom_range(255)), 6'($urandom_range(63)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic push_packet(int body_len, bit terminated, bit honest, bit closed);
      int total;
      int k;
      logic [7:0] b;
      logic [5:0] declared;
      total = body_len + (terminated ? 2 : 0);
      declared = honest ? total[5:0] : 6'($urandom_range(63));
      for (k = 0; k < total; k++) begin
         if (k < body_len) b = 8'($urandom_range(255));
         else if (k == body_len) b = term_a;
         else b = term_b;
         push_op(MODE_WRITE, b, declared, k == 0, closed && k == total - 1);
      end
   endtask

   task automatic push_mix(int count);
      int goal;
      int r;
      int body;
      bit terminated;
      goal = ops_planned + count;
      while (ops_planned < goal) begin
         r = $urandom_range(99);
         if (r < 50) begin
            body = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 8);
            terminated = ($urandom_range(9) != 0);
            if (!terminated && body == 0) body = 1;
            push_packet(body, terminated, $urandom_range(6) != 0, $urandom_range(19) != 0);
         end else if (r < 80) begin
            push_read();
         end else begin
            push_op(MODE_WRITE, 8'($urandom_range(255)), 6'($urandom_range(63)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_END_FIRST) term_a = val;
      else if (idx == CSR_END_SECOND) term_b = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_ring_quiet();
      while (ring_ops.size() != 0 || req_valid || ring_results_due.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            ring_step(on_wire);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (ring_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = ring_ops.pop_front();
               req_valid <= 1'b1;
               req_mode <= on_wire.mode;
               req_data_byte <= on_wire.data;
               req_packet_len <= on_wire.len;
               req_first_of_packet <= on_wire.first;
               req_last_of_packet <= on_wire.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      ring_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (rsp_status == ST_MSG) msg_bytes++;
         if (rsp_status == ST_DROPPED) dropped_bytes++;
         if (ring_results_due.size() == 0) begin
            $error("unexpected result word: out_byte %0h status %0d last %0b",
                   rsp_out_byte, rsp_status, rsp_last);
            fail_count++;
         end else begin
            want = ring_results_due.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h actual %0h", want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_status !== want.st) begin
               $error("status: expected %0d actual %0d", want.st, rsp_status);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b actual %0b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stim_phase == 2 && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #20000000;
      $display("byte_ring_with_delimited_reads verification failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_SPARE, 8'hFF);

      // Opening cases under the reset terminator.
      push_read();
      push_op(MODE_WRITE, 8'hFF, 6'd5, 1'b0, 1'b0);
      push_op(MODE_WRITE, 8'h00, 6'd0, 1'b1, 1'b0);
      push_op(MODE_WRITE, 8'hFF, 6'd0, 1'b0, 1'b0);
      push_op(MODE_WRITE, term_a, 6'd0, 1'b0, 1'b0);
      push_op(MODE_WRITE, term_b, 6'd0, 1'b0, 1'b1);
      push_op(MODE_READ, 8'hFF, 6'd63, 1'b1, 1'b1);
      push_packet(0, 1'b1, 1'b1, 1'b1);
      push_read();
      push_op(MODE_WRITE, 8'h41, 6'd63, 1'b1, 1'b0);
      push_op(MODE_WRITE, 8'h42, 6'd63, 1'b0, 1'b1);
      push_op(MODE_WRITE, 8'h55, 6'd2, 1'b1, 1'b0);
      push_op(MODE_WRITE, 8'hAA, 6'd2, 1'b0, 1'b1);
      push_read();
      push_op(MODE_WRITE, 8'h80, 6'd0, 1'b1, 1'b1);
      push_packet(1, 1'b1, 1'b1, 1'b1);
      push_read();
      push_read();
      push_mix(35);
      wait_ring_quiet();

      csr_write(CSR_END_FIRST, 8'hFF);
      csr_write(CSR_END_SECOND, 8'h00);
      send_idle_pct = 80;
      recv_idle_pct = 28;
      stim_phase = 1;
      push_mix(35);
      wait_ring_quiet();

      csr_write(CSR_END_FIRST, 8'h00);
      csr_write(CSR_END_SECOND, 8'hFF);
      csr_write(CSR_SPARE, 8'h5A);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stim_phase = 2;
      push_mix(35);
      wait_ring_quiet();

      $display("Covered %0d request words and %0d result words under three terminator settings.",
               words_sent, words_checked);
      $display("Of those results, %0d were message bytes and %0d were dropped bytes.",
               msg_bytes, dropped_bytes);
      if (fail_count == 0) begin
         $display("byte_ring_with_delimited_reads verification clean");
      end else begin
         $display("byte_ring_with_delimited_reads verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/brdr_pkg.sv
design/brdr_mem.sv
design/brdr_match.sv
design/byte_ring_with_delimited_reads.sv
dv/byte_ring_with_delimited_reads_tb.sv
